@@ hdl/dq_pkg.sv @@
// Shared definitions for the double-ended queue: action and status codes,
// default sizes, and the command/status structs between controller and datapath.
// No dependencies.
package dq_pkg;

	// Default sizes
	localparam int DQ_DEPTH      = 16;
	localparam int DQ_DATA_WIDTH = 32;

	// Port field widths
	localparam int ACTION_W = 3;
	localparam int VALUE_W  = 32;
	localparam int COUNT_W  = 5;
	localparam int STATUS_W = 2;

	// Action codes
	localparam logic [ACTION_W-1:0] ACT_NONE       = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_PUSH_BACK  = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_POP_BACK   = 3'd4;
	localparam logic [ACTION_W-1:0] ACT_CLEAR      = 3'd5;
	localparam logic [ACTION_W-1:0] ACT_REVERSE    = 3'd6;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_POP_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_PUSH_FULL = 2'd2;

	// Front/back value reported for an empty queue
	localparam logic [VALUE_W-1:0] EMPTY_VALUE = '1;

	// Controller to datapath
	typedef struct packed {
		logic                put_low;     // add at low end of the run
		logic                put_high;    // add at high end of the run
		logic                take_low;    // drop low end
		logic                take_high;   // drop high end
		logic                clear;
		logic                flip;        // toggle direction flag
		logic                issue_read;  // read both ends into the result regs
		logic                load_status; // item accepted: capture its status
		logic [STATUS_W-1:0] status;      // status code of the accepted item
	} dq_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic full;
		logic empty;
		logic reversed;
	} dq_stat_t;

endpackage

@@ hdl/dq_ctrl.sv @@
// Controller for the double-ended queue: handshake sequencing and action decode.
// Depends on dq_pkg.
module dq_ctrl
	import dq_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [ACTION_W-1:0] action,
	output logic                out_valid,
	input  logic                out_stall,
	input  dq_stat_t            stat,
	output dq_cmd_t             cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_READ = 2'd1;
	localparam logic [1:0] S_SHOW = 2'd2;

	logic [1:0] state_q;
	logic       accept;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = (state_q == S_SHOW);
	assign accept    = in_valid && !in_stall;

	// State sequencing: apply, read ends, hold result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) state_q <= S_READ;
				end
				S_READ: begin
					state_q <= S_SHOW;
				end
				S_SHOW: begin
					if (!out_stall) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Action decode; front is the low end unless reversed
	always_comb begin
		cmd             = '0;
		cmd.status      = ST_OK;
		cmd.issue_read  = (state_q == S_READ);
		cmd.load_status = accept;
		if (accept) begin
			if (action inside {ACT_PUSH_FRONT, ACT_PUSH_BACK}) begin
				if (stat.full) begin
					cmd.status = ST_PUSH_FULL;
				end else if ((action == ACT_PUSH_FRONT) != stat.reversed) begin
					cmd.put_low = 1'b1;
				end else begin
					cmd.put_high = 1'b1;
				end
			end else if (action inside {ACT_POP_FRONT, ACT_POP_BACK}) begin
				if (stat.empty) begin
					cmd.status = ST_POP_EMPTY;
				end else if ((action == ACT_POP_FRONT) != stat.reversed) begin
					cmd.take_low = 1'b1;
				end else begin
					cmd.take_high = 1'b1;
				end
			end else if (action == ACT_CLEAR) begin
				cmd.clear = 1'b1;
			end else if (action == ACT_REVERSE) begin
				cmd.flip = 1'b1;
			end
		end
	end

endmodule

@@ hdl/dq_datapath.sv @@
// Datapath for the double-ended queue: ring pointers, slot memory, result regs.
// Depends on dq_pkg; driven by dq_ctrl commands.
module dq_datapath
	import dq_pkg::*;
#(
	parameter int DEPTH      = DQ_DEPTH,
	parameter int DATA_WIDTH = DQ_DATA_WIDTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  dq_cmd_t                    cmd,
	output dq_stat_t                   stat,
	input  logic signed [VALUE_W-1:0]  value,
	output logic signed [VALUE_W-1:0]  front_value,
	output logic signed [VALUE_W-1:0]  back_value,
	output logic        [COUNT_W-1:0]  count,
	output logic                       is_empty,
	output logic        [STATUS_W-1:0] status
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int SUM_W = PTR_W + 1;
	localparam logic [PTR_W-1:0] LAST_IDX  = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);
	localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(DEPTH);

	logic [DATA_WIDTH-1:0]        mem [DEPTH];
	logic [PTR_W-1:0]             head_q;
	logic [CNT_W-1:0]             count_q;
	logic                         rev_q;
	logic [STATUS_W-1:0]          status_q;
	logic signed [DATA_WIDTH-1:0] rd_lo_q;
	logic signed [DATA_WIDTH-1:0] rd_hi_q;

	logic [PTR_W-1:0]      head_dec;
	logic [PTR_W-1:0]      head_inc;
	logic [PTR_W-1:0]      tail_idx;
	logic [PTR_W-1:0]      last_idx;
	logic [PTR_W-1:0]      wr_addr;
	logic                  wr_en;
	logic [63:0]           value_ext;
	logic [DATA_WIDTH-1:0] wr_data;
	logic [63:0]           lo_ext;
	logic [63:0]           hi_ext;
	logic [VALUE_W-1:0]    lo_rep;
	logic [VALUE_W-1:0]    hi_rep;

	// Ring add; both operands below DEPTH so one conditional subtract suffices
	function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] a,
		input logic [PTR_W-1:0] b);
		logic [SUM_W-1:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		if (sum >= DEPTH_SUM) sum = sum - DEPTH_SUM;
		return sum[PTR_W-1:0];
	endfunction

	// Index arithmetic
	assign head_dec = (head_q == '0) ? LAST_IDX : head_q - 1'b1;
	assign head_inc = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
	assign tail_idx = ring_add(head_q, count_q[PTR_W-1:0]);
	assign last_idx = ring_add(head_q, PTR_W'(count_q - 1'b1));

	assign stat.full     = (count_q == FULL_CNT);
	assign stat.empty    = (count_q == '0);
	assign stat.reversed = rev_q;

	// Slot write
	assign value_ext = 64'(value);
	assign wr_data   = value_ext[DATA_WIDTH-1:0];
	assign wr_en     = cmd.put_low || cmd.put_high;
	assign wr_addr   = cmd.put_low ? head_dec : tail_idx;

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
	end

	// Registered reads of both ends of the run
	always_ff @(posedge clk) begin
		if (cmd.issue_read) begin
			rd_lo_q <= mem[head_q];
			rd_hi_q <= mem[last_idx];
		end
	end

	// Pointer, count and flag update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
			rev_q   <= 1'b0;
		end else if (cmd.clear) begin
			head_q  <= '0;
			count_q <= '0;
			rev_q   <= 1'b0;
		end else begin
			if (cmd.put_low)  head_q <= head_dec;
			if (cmd.take_low) head_q <= head_inc;
			if (cmd.put_low || cmd.put_high) count_q <= count_q + 1'b1;
			if (cmd.take_low || cmd.take_high) count_q <= count_q - 1'b1;
			if (cmd.flip) rev_q <= ~rev_q;
		end
	end

	// Status of the accepted item, held until the next one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q <= ST_OK;
		end else if (cmd.load_status) begin
			status_q <= cmd.status;
		end
	end

	// Result fields, sign-extended from the stored width
	assign lo_ext = 64'(rd_lo_q);
	assign hi_ext = 64'(rd_hi_q);
	assign lo_rep = lo_ext[VALUE_W-1:0];
	assign hi_rep = hi_ext[VALUE_W-1:0];

	assign is_empty    = (count_q == '0);
	assign front_value = is_empty ? EMPTY_VALUE : (rev_q ? hi_rep : lo_rep);
	assign back_value  = is_empty ? EMPTY_VALUE : (rev_q ? lo_rep : hi_rep);
	assign count       = COUNT_W'(count_q);
	assign status      = status_q;

	// Checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("stored count beyond depth");

	a_one_update: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.put_low, cmd.put_high, cmd.take_low, cmd.take_high,
			cmd.clear, cmd.flip}))
		else $error("more than one queue update in a cycle");

	a_push_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.put_low || cmd.put_high) |=> (count_q == $past(count_q) + 1'b1))
		else $error("push did not grow the count");

	a_clear_resets: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |=> (count_q == '0 && head_q == '0 && !rev_q))
		else $error("clear left state behind");

endmodule

@@ hdl/double_ended_queue.sv @@
// Bounded double-ended queue of signed values in a ring of DEPTH slots.
// Each item carries one action (none, push front/back, pop front/back, clear,
// reverse) and produces exactly one result with the front and back values,
// count, empty flag and status. The accept edge updates head, count and direction
// flag and writes at most one slot; the S_READ state then reads both ends of the
// run from the single slot memory into registers; S_SHOW presents the result,
// which holds until taken. The next item is accepted in the cycle after the
// result is taken, so items do not overlap. Reverse only flips a direction flag.
// Slots hold DATA_WIDTH bits and are sign-extended to 32 bits when reported.
// Depends on dq_pkg, dq_ctrl and dq_datapath.
module double_ended_queue
	import dq_pkg::*;
#(
	parameter int DEPTH      = DQ_DEPTH,
	parameter int DATA_WIDTH = DQ_DATA_WIDTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic        [ACTION_W-1:0] action,
	input  logic signed [VALUE_W-1:0]  value,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [VALUE_W-1:0]  front_value,
	output logic signed [VALUE_W-1:0]  back_value,
	output logic        [COUNT_W-1:0]  count,
	output logic                       is_empty,
	output logic        [STATUS_W-1:0] status
);

	dq_cmd_t  cmd;
	dq_stat_t stat;

	dq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.action    (action),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	dq_datapath #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.value       (value),
		.front_value (front_value),
		.back_value  (back_value),
		.count       (count),
		.is_empty    (is_empty),
		.status      (status)
	);

endmodule

@@ dv/double_ended_queue_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for double_ended_queue: a directed action table, then
// biased random fill/drain traffic, checked against table values or an in-bench deque model.
// Depends on dq_pkg and the double_ended_queue RTL.
module double_ended_queue_tb
	import dq_pkg::*;
();

	localparam logic [ACTION_W-1:0] ACT_UNUSED = 3'd7;
	localparam int RAND_ITEMS  = 650;
	localparam int HOLD_CYCLES = 200;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_WAIT  = 12;

	// One result as the block reports it
	typedef struct {
		logic signed [VALUE_W-1:0] front;
		logic signed [VALUE_W-1:0] back;
		logic [COUNT_W-1:0]        cnt;
		logic                      empty;
		logic [STATUS_W-1:0]       st;
	} deque_view_t;

	// One line of the directed action table
	typedef struct {
		logic [ACTION_W-1:0] act;
		logic [VALUE_W-1:0]  val;
		int                  reps;
		bit                  typed;
		deque_view_t         want;
	} action_row_t;

	logic                       clk;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_stall;
	logic        [ACTION_W-1:0] action;
	logic signed [VALUE_W-1:0]  value;
	logic                       out_valid;
	logic                       out_stall;
	logic signed [VALUE_W-1:0]  front_value;
	logic signed [VALUE_W-1:0]  back_value;
	logic        [COUNT_W-1:0]  count;
	logic                       is_empty;
	logic        [STATUS_W-1:0] status;

	// Deque model state
	logic [VALUE_W-1:0] ring_mem [DQ_DEPTH];
	int                 head_idx = 0;
	int                 fill = 0;
	bit                 flipped = 1'b0;

	deque_view_t pending_views [$];
	action_row_t action_table [$];
	int          error_count = 0;
	int          cycle_count = 0;
	bit          tx_idle_on = 1'b0;
	bit          rx_idle_on = 1'b0;
	bit          quiet_tail = 1'b0;
	bit          hold_request = 1'b0;

	double_ended_queue u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.action      (action),
		.value       (value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.front_value (front_value),
		.back_value  (back_value),
		.count       (count),
		.is_empty    (is_empty),
		.status      (status)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time, pending_views.size());
			$display("Verification failed");
			$finish;
		end
	end

	// Apply one action to the model and return the result it reports
	function automatic deque_view_t apply_action(input logic [ACTION_W-1:0] act,
			input logic [VALUE_W-1:0] val);
		deque_view_t v;
		bit at_low;
		logic [VALUE_W-1:0] lo_val, hi_val;
		v.st = ST_OK;
		case (act)
			ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
				if (fill >= DQ_DEPTH) begin
					v.st = ST_PUSH_FULL;
				end else begin
					// front sits at the low end unless the order is flipped
					at_low = (act == ACT_PUSH_FRONT) ^ flipped;
					if (at_low) begin
						head_idx = (head_idx + DQ_DEPTH - 1) % DQ_DEPTH;
						ring_mem[head_idx] = val;
					end else begin
						ring_mem[(head_idx + fill) % DQ_DEPTH] = val;
					end
					fill++;
				end
			end
			ACT_POP_FRONT, ACT_POP_BACK: begin
				if (fill == 0) begin
					v.st = ST_POP_EMPTY;
				end else begin
					at_low = (act == ACT_POP_FRONT) ^ flipped;
					if (at_low)
						head_idx = (head_idx + 1) % DQ_DEPTH;
					fill--;
				end
			end
			ACT_CLEAR: begin
				fill = 0;
				head_idx = 0;
				flipped = 1'b0;
			end
			ACT_REVERSE: flipped = !flipped;
			default: ;
		endcase
		if (fill == 0) begin
			v.front = EMPTY_VALUE;
			v.back = EMPTY_VALUE;
		end else begin
			lo_val = ring_mem[head_idx];
			hi_val = ring_mem[(head_idx + fill - 1) % DQ_DEPTH];
			v.front = flipped ? hi_val : lo_val;
			v.back = flipped ? lo_val : hi_val;
		end
		v.cnt = COUNT_W'(fill);
		v.empty = (fill == 0);
		return v;
	endfunction

	function automatic void add_row(input logic [ACTION_W-1:0] act,
			input logic [VALUE_W-1:0] val, input int reps, input bit typed,
			input logic [VALUE_W-1:0] f, input logic [VALUE_W-1:0] b,
			input int c, input bit e, input logic [STATUS_W-1:0] s);
		action_row_t r;
		r.act = act;
		r.val = val;
		r.reps = reps;
		r.typed = typed;
		r.want.front = f;
		r.want.back = b;
		r.want.cnt = COUNT_W'(c);
		r.want.empty = e;
		r.want.st = s;
		action_table.insert(action_table.size(), r);
	endfunction

	// Offer one item, wait for it to be taken, then record its expected result
	task automatic send_item(input logic [ACTION_W-1:0] act, input logic [VALUE_W-1:0] val,
			input bit typed, input deque_view_t want);
		deque_view_t predicted;
		if (tx_idle_on && !quiet_tail && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end
		action <= act;
		value <= val;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		predicted = apply_action(act, val);
		pending_views.insert(pending_views.size(), typed ? want : predicted);
		@(negedge clk);
	endtask

	// Receiver pacing: random stall bursts and one long hold-off
	initial begin : rx_pacer
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_request = 1'b0;
				out_stall <= 1'b0;
			end else if (rx_idle_on && !quiet_tail && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 18)) @(negedge clk);
				out_stall <= 1'b0;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	function automatic void check_field(input string name, input logic [VALUE_W-1:0] exp_v,
			input logic [VALUE_W-1:0] got_v);
		if (got_v !== exp_v) begin
			$display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, got_v);
			error_count++;
		end
	endfunction

	// Compare every taken result with the oldest expectation
	always @(posedge clk) begin
		deque_view_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_views.size() == 0) begin
				$display("%0t: unexpected result, expected none actual front %h back %h count %0d",
					$time, front_value, back_value, count);
				error_count++;
			end else begin
				want = pending_views[0];
				pending_views.delete(0);
				check_field("front_value", want.front, front_value);
				check_field("back_value", want.back, back_value);
				check_field("count", VALUE_W'(want.cnt), VALUE_W'(count));
				check_field("is_empty", VALUE_W'(want.empty), VALUE_W'(is_empty));
				check_field("status", VALUE_W'(want.st), VALUE_W'(status));
			end
		end
	end

	initial begin : stimulus
		deque_view_t none_view;
		logic [ACTION_W-1:0] act;
		logic [VALUE_W-1:0] val;
		int push_pct, pop_pct, r;

		none_view = '{default: '0};
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = ACT_NONE;
		value = '0;
		foreach (ring_mem[i]) ring_mem[i] = '0;

		// Directed table: empty-queue cases, extremes, fill to full, mixed ends, clear
		add_row(ACT_POP_FRONT, 0, 1, 1, EMPTY_VALUE, EMPTY_VALUE, 0, 1, ST_POP_EMPTY);
		add_row(ACT_POP_BACK, 0, 1, 1, EMPTY_VALUE, EMPTY_VALUE, 0, 1, ST_POP_EMPTY);
		add_row(ACT_NONE, 32'h1234_5678, 1, 1, EMPTY_VALUE, EMPTY_VALUE, 0, 1, ST_OK);
		add_row(ACT_UNUSED, 32'hdead_beef, 1, 1, EMPTY_VALUE, EMPTY_VALUE, 0, 1, ST_OK);
		add_row(ACT_REVERSE, 0, 1, 1, EMPTY_VALUE, EMPTY_VALUE, 0, 1, ST_OK);
		add_row(ACT_CLEAR, 0, 1, 1, EMPTY_VALUE, EMPTY_VALUE, 0, 1, ST_OK);
		add_row(ACT_PUSH_FRONT, 32'h7fff_ffff, 1, 1, 32'h7fff_ffff, 32'h7fff_ffff, 1, 0, ST_OK);
		add_row(ACT_REVERSE, 0, 1, 1, 32'h7fff_ffff, 32'h7fff_ffff, 1, 0, ST_OK);
		add_row(ACT_PUSH_BACK, 32'h8000_0000, 1, 1, 32'h7fff_ffff, 32'h8000_0000, 2, 0, ST_OK);
		add_row(ACT_PUSH_FRONT, 32'h0, 14, 0, 0, 0, 0, 0, ST_OK);
		add_row(ACT_PUSH_BACK, 32'h1, 1, 1, 32'h0, 32'h8000_0000, 16, 0, ST_PUSH_FULL);
		add_row(ACT_PUSH_FRONT, 32'hffff_ffff, 1, 0, 0, 0, 0, 0, ST_OK);
		add_row(ACT_POP_FRONT, 0, 1, 0, 0, 0, 0, 0, ST_OK);
		add_row(ACT_POP_BACK, 0, 1, 0, 0, 0, 0, 0, ST_OK);
		add_row(ACT_REVERSE, 0, 1, 0, 0, 0, 0, 0, ST_OK);
		add_row(ACT_PUSH_BACK, 32'hffff_ffff, 1, 0, 0, 0, 0, 0, ST_OK);
		add_row(ACT_PUSH_FRONT, 32'h5555_5555, 1, 0, 0, 0, 0, 0, ST_OK);
		add_row(ACT_POP_BACK, 0, 1, 0, 0, 0, 0, 0, ST_OK);
		add_row(ACT_CLEAR, 0, 1, 1, EMPTY_VALUE, EMPTY_VALUE, 0, 1, ST_OK);

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (action_table[i])
			repeat (action_table[i].reps)
				send_item(action_table[i].act, action_table[i].val, action_table[i].typed,
					action_table[i].want);

		// Random traffic in phases that lean toward filling, draining or neither
		push_pct = 40;
		pop_pct = 40;
		for (int i = 0; i < RAND_ITEMS; i++) begin
			if (i % 48 == 0) begin
				case ($urandom_range(0, 2))
					0: begin push_pct = 40; pop_pct = 40; end
					1: begin push_pct = 72; pop_pct = 20; end
					default: begin push_pct = 20; pop_pct = 72; end
				endcase
				tx_idle_on = ($urandom_range(0, 3) != 0);
				rx_idle_on = ($urandom_range(0, 3) != 0);
			end
			if (i == 160)
				hold_request = 1'b1;
			if (i == RAND_ITEMS - 80)
				quiet_tail = 1'b1;

			r = $urandom_range(0, 99);
			if (r < push_pct)
				act = $urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
			else if (r < push_pct + pop_pct)
				act = $urandom_range(0, 1) ? ACT_POP_FRONT : ACT_POP_BACK;
			else begin
				case ($urandom_range(0, 9))
					0: act = ACT_CLEAR;
					1, 2, 3, 4, 5: act = ACT_REVERSE;
					6, 7: act = ACT_NONE;
					default: act = ACT_UNUSED;
				endcase
			end

			// Mostly random payloads, with the sign extremes mixed in
			case ($urandom_range(0, 11))
				0: val = 32'h7fff_ffff;
				1: val = 32'h8000_0000;
				2: val = '1;
				3: val = '0;
				default: val = $urandom;
			endcase
			send_item(act, val, 1'b0, none_view);
		end
		in_valid <= 1'b0;

		wait (pending_views.size() == 0);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (error_count == 0 && pending_views.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

@@ double_ended_queue.f @@
hdl/dq_pkg.sv
hdl/dq_ctrl.sv
hdl/dq_datapath.sv
hdl/double_ended_queue.sv
dv/double_ended_queue_tb.sv
